[rtl/arp_pkg.sv]
//------------------------------------------------------------------------------
// arp_pkg
// Shared types and constants for the address range pool.
//------------------------------------------------------------------------------
package arp_pkg;

  localparam int MAX_RANGES = 64;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_INIT    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  // per-cell update command, same for all cells
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_SHDOWN = 3'd2,  // cells at or above pos take the upper neighbor
    OP_SHUP   = 3'd3,  // cells above pos take the lower neighbor
    OP_WRITE  = 3'd4   // only cell pos is written
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;
    logic             wr_first;
    logic             wr_last;
    logic [31:0]      first;
    logic [31:0]      last;
    logic             ins;     // with OP_SHUP: cell pos takes first/last
  } cell_cmd_t;

  // per-cell compare flags back to the controller
  typedef struct packed {
    logic valid;
    logic last_lt;   // last < a
    logic first_le;  // first <= a
  } cell_flag_t;

endpackage

[rtl/address_range_pool.sv]
//------------------------------------------------------------------------------
// address_range_pool
// Free-address pool of one subnet held as a sorted chain of range cells.
//------------------------------------------------------------------------------
// Usage: raise start with in_mode/in_address while busy is low; the word is
// taken at that edge. busy is high for one cycle while all cells compare the
// address in parallel and the controller picks one shift/write command. On
// the next edge out_valid pulses for one cycle with out_granted_address and
// out_status. A merge or split needs a second cell write, done at the end of
// the result cycle; busy stays high through it. No new request is taken until
// the last one and its fix-up write are through; the cell chain does one
// shift per cycle. The receiver cannot stall. cfg_we/cfg_index/cfg_data
// write network_base (index 0) or network_mask (index 1), one per write.
// Reset empties the pool and loads mask 0xFFFFFF00, base 0, not range contents.
//------------------------------------------------------------------------------
module address_range_pool (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_address,
  output logic        out_valid,
  output logic [31:0] out_granted_address,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int N = arp_pkg::MAX_RANGES;

  logic [31:0] base_r, mask_r;
  logic [N-1:0][31:0] firsts, lasts;
  arp_pkg::cell_flag_t [N-1:0] flags;
  logic [31:0] addr;
  logic [arp_pkg::CNT_W-1:0] count;
  arp_pkg::cell_cmd_t cmd;
  logic busy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      mask_r <= 32'hFFFF_FF00;
    end else if (cfg_we) begin
      if (cfg_index) mask_r <= cfg_data;
      else           base_r <= cfg_data;
    end
  end

  arp_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy(busy_i), .in_mode, .in_address,
    .base(base_r), .mask(mask_r), .flags, .firsts, .lasts,
    .addr, .count, .cell_cmd(cmd), .out_valid, .out_granted_address, .out_status
  );

  assign busy = busy_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    arp_cell u_cell (
      .clk,
      .idx(arp_pkg::CNT_W'(g)),
      .count,
      .addr,
      .cmd,
      .lo_first(firsts[(g == 0) ? 0 : g - 1]),
      .lo_last (lasts [(g == 0) ? 0 : g - 1]),
      .hi_first(firsts[(g == N - 1) ? g : g + 1]),
      .hi_last (lasts [(g == N - 1) ? g : g + 1]),
      .first(firsts[g]),
      .last(lasts[g]),
      .flag(flags[g])
    );
  end

endmodule

[rtl/arp_cell.sv]
//------------------------------------------------------------------------------
// arp_cell
// One range entry: holds first/last, compares against the request address,
// shifts with its neighbors.
//------------------------------------------------------------------------------
module arp_cell (
  input  logic                      clk,
  input  logic [arp_pkg::CNT_W-1:0] idx,
  input  logic [arp_pkg::CNT_W-1:0] count,
  input  logic [31:0]               addr,
  input  arp_pkg::cell_cmd_t        cmd,
  input  logic [31:0]               lo_first,
  input  logic [31:0]               lo_last,
  input  logic [31:0]               hi_first,
  input  logic [31:0]               hi_last,
  output logic [31:0]               first,
  output logic [31:0]               last,
  output arp_pkg::cell_flag_t       flag
);

  logic [31:0] first_r, last_r, first_nxt, last_nxt;

  assign first = first_r;
  assign last  = last_r;
  assign flag.valid    = idx < count;
  assign flag.last_lt  = last_r < addr;
  assign flag.first_le = first_r <= addr;

  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    case (cmd.op)
      arp_pkg::OP_SHDOWN: begin
        if (idx >= cmd.pos) begin
          first_nxt = hi_first;
          last_nxt  = hi_last;
        end
      end
      arp_pkg::OP_SHUP: begin
        if (idx > cmd.pos) begin
          first_nxt = lo_first;
          last_nxt  = lo_last;
        end else if (idx == cmd.pos && cmd.ins) begin
          first_nxt = cmd.first;
          last_nxt  = cmd.last;
        end
      end
      arp_pkg::OP_WRITE: begin
        if (idx == cmd.pos) begin
          if (cmd.wr_first) first_nxt = cmd.first;
          if (cmd.wr_last)  last_nxt  = cmd.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

endmodule

[rtl/arp_ctrl.sv]
//------------------------------------------------------------------------------
// arp_ctrl
// Request sequencer: latches a request, reads the cell flags, issues one cell
// command (plus a fix-up write for a merge or split) and the result word.
//------------------------------------------------------------------------------
module arp_ctrl (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  output logic                                         busy,
  input  logic [1:0]                                   in_mode,
  input  logic [31:0]                                  in_address,
  input  logic [31:0]                                  base,
  input  logic [31:0]                                  mask,
  input  arp_pkg::cell_flag_t [arp_pkg::MAX_RANGES-1:0] flags,
  input  logic [arp_pkg::MAX_RANGES-1:0][31:0]         firsts,
  input  logic [arp_pkg::MAX_RANGES-1:0][31:0]         lasts,
  output logic [31:0]                                  addr,
  output logic [arp_pkg::CNT_W-1:0]                    count,
  output arp_pkg::cell_cmd_t                           cell_cmd,
  output logic                                         out_valid,
  output logic [31:0]                                  out_granted_address,
  output logic [2:0]                                   out_status
);

  localparam int IW = $clog2(arp_pkg::MAX_RANGES);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                    state_r;
  arp_pkg::mode_t            mode_r;
  logic [31:0]               addr_r;
  logic [arp_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [arp_pkg::CNT_W-1:0] slot;
  logic                      found;
  logic [IW-1:0]             si, sp;
  logic [31:0]               f_i, l_i, l_p;
  logic                      in_rng, has_i, has_p, j_after, j_before, full;
  logic [31:0]               init_f, init_l;
  arp_pkg::status_t          st;
  logic [31:0]               gr;
  arp_pkg::cell_cmd_t        cmd;

  // second fix-up for merge and split handled via a pending write
  logic                      fix_r;
  logic [arp_pkg::CNT_W-1:0] fix_pos_r;
  logic                      fix_first_r;
  logic [31:0]               fix_val_r;
  arp_pkg::cell_cmd_t        cmd_out;

  assign busy     = (state_r == S_EXEC) || fix_r;
  assign addr     = addr_r;
  assign count    = count_r;
  assign cell_cmd = cmd_out;

  // first cell whose last >= a, else count
  always_comb begin
    slot  = count_r;
    found = 1'b0;
    for (int k = 0; k < arp_pkg::MAX_RANGES; k++) begin
      if (!found && flags[k].valid && !flags[k].last_lt) begin
        slot  = arp_pkg::CNT_W'(k);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    si       = slot[IW-1:0];
    sp       = si - IW'(1);
    has_i    = slot < count_r;
    has_p    = slot != '0;
    f_i      = firsts[si];
    l_i      = lasts[si];
    l_p      = lasts[sp];
    in_rng   = has_i && flags[si].first_le;
    j_after  = has_i && (f_i - 32'd1 == addr_r);
    j_before = has_p && (l_p + 32'd1 == addr_r);
    full     = count_r >= arp_pkg::CNT_W'(arp_pkg::MAX_RANGES);
    init_f   = base + 32'd1;
    init_l   = base + ~mask - 32'd1;
    st        = arp_pkg::ST_OK;
    gr        = '0;
    count_nxt = count_r;
    cmd       = '0;
    cmd.op    = arp_pkg::OP_HOLD;
    case (mode_r)
      arp_pkg::MODE_ALLOC: begin
        if (count_r == '0) begin
          st = arp_pkg::ST_EMPTY;
        end else begin
          gr = firsts[0];
          if (firsts[0] == lasts[0]) begin
            cmd.op    = arp_pkg::OP_SHDOWN;
            count_nxt = count_r - arp_pkg::CNT_W'(1);
          end else begin
            cmd.op       = arp_pkg::OP_WRITE;
            cmd.wr_first = 1'b1;
            cmd.first    = firsts[0] + 32'd1;
          end
        end
      end
      arp_pkg::MODE_RELEASE: begin
        if (in_rng) begin
          st = arp_pkg::ST_DUP;
        end else if (j_after && j_before) begin
          // cell slot-1 takes range slot's last, slot removed
          cmd.op = arp_pkg::OP_SHDOWN;
          cmd.pos = slot;
          count_nxt = count_r - arp_pkg::CNT_W'(1);
        end else if (j_after) begin
          cmd.op = arp_pkg::OP_WRITE; cmd.pos = slot;
          cmd.wr_first = 1'b1; cmd.first = addr_r;
        end else if (j_before) begin
          cmd.op = arp_pkg::OP_WRITE; cmd.pos = slot - arp_pkg::CNT_W'(1);
          cmd.wr_last = 1'b1; cmd.last = addr_r;
        end else if (full) begin
          st = arp_pkg::ST_FULL;
        end else begin
          cmd.op = arp_pkg::OP_SHUP; cmd.pos = slot; cmd.ins = 1'b1;
          cmd.first = addr_r; cmd.last = addr_r;
          count_nxt = count_r + arp_pkg::CNT_W'(1);
        end
      end
      arp_pkg::MODE_RESERVE: begin
        if (!in_rng) begin
          st = arp_pkg::ST_ABSENT;
        end else if (l_i == addr_r) begin
          if (f_i == addr_r) begin
            cmd.op = arp_pkg::OP_SHDOWN; cmd.pos = slot;
            count_nxt = count_r - arp_pkg::CNT_W'(1);
          end else begin
            cmd.op = arp_pkg::OP_WRITE; cmd.pos = slot;
            cmd.wr_last = 1'b1; cmd.last = addr_r - 32'd1;
          end
        end else if (f_i == addr_r) begin
          cmd.op = arp_pkg::OP_WRITE; cmd.pos = slot;
          cmd.wr_first = 1'b1; cmd.first = addr_r + 32'd1;
        end else if (full) begin
          st = arp_pkg::ST_FULL;
        end else begin
          // duplicate slot upward, then new lower piece at slot
          cmd.op = arp_pkg::OP_SHUP; cmd.pos = slot; cmd.ins = 1'b1;
          cmd.first = f_i; cmd.last = addr_r - 32'd1;
          count_nxt = count_r + arp_pkg::CNT_W'(1);
        end
      end
      default: begin
        cmd.op = arp_pkg::OP_WRITE;
        cmd.wr_first = 1'b1; cmd.wr_last = 1'b1;
        cmd.first = init_f; cmd.last = init_l;
        count_nxt = (init_f <= init_l) ? arp_pkg::CNT_W'(1) : '0;
      end
    endcase
  end

  always_comb begin
    cmd_out = cmd;
    if (state_r != S_EXEC) begin
      cmd_out = '0;
      cmd_out.op = fix_r ? arp_pkg::OP_WRITE : arp_pkg::OP_HOLD;
      cmd_out.pos = fix_pos_r;
      cmd_out.wr_first = fix_first_r;
      cmd_out.wr_last = !fix_first_r;
      cmd_out.first = fix_val_r;
      cmd_out.last = fix_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
      fix_r     <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      fix_r     <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !fix_r) begin
            state_r <= S_EXEC;
            mode_r  <= arp_pkg::mode_t'(in_mode);
            addr_r  <= in_address;
          end
        end
        S_EXEC: begin
          state_r             <= S_IDLE;
          count_r             <= count_nxt;
          out_valid           <= 1'b1;
          out_granted_address <= gr;
          out_status          <= st;
          fix_pos_r           <= slot - arp_pkg::CNT_W'(1);
          fix_first_r         <= 1'b0;
          fix_val_r           <= l_i;
          if (st == arp_pkg::ST_OK && mode_r == arp_pkg::MODE_RELEASE
              && j_after && j_before) begin
            fix_r <= 1'b1;
          end
          if (st == arp_pkg::ST_OK && mode_r == arp_pkg::MODE_RESERVE
              && cmd.op == arp_pkg::OP_SHUP) begin
            fix_r       <= 1'b1;
            fix_pos_r   <= slot + arp_pkg::CNT_W'(1);
            fix_first_r <= 1'b1;
            fix_val_r   <= addr_r + 32'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/arp_checker.sv]
//------------------------------------------------------------------------------
// arp_checker
// Port-level checks for the address range pool.
//------------------------------------------------------------------------------
module arp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_granted_address,
  input logic [2:0]  out_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept without busy");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid ##1 out_valid) else $error("missing result");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= arp_pkg::ST_FULL) else $error("bad status");

  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != arp_pkg::ST_OK |-> out_granted_address == 32'd0)
    else $error("grant on failure");

endmodule

bind address_range_pool arp_checker u_arp_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_granted_address, .out_status
);
